[src/vpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared types and constants of the virtual to physical translator.
// ----------------------------------------------------------------------------
package vpt_pkg;

	// page size must be a power of two: page number and offset are a bit split
	localparam int PAGE_BYTES  = 128;
	localparam int OFFSET_W    = $clog2(PAGE_BYTES);
	localparam int TLB_SLOTS   = 4;
	localparam int TLB_IW      = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
	localparam int FRAME_COUNT = 32;
	localparam int TABLE_DEPTH = 64;
	localparam int PT_AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int OP_W          = 3;
	localparam int STATUS_W      = 3;
	localparam int INDEX_W       = 6;
	localparam int VPAGE_W       = 25;
	localparam int FRAME_W       = 8;
	localparam int PHYS_W        = 12;
	localparam int TABLE_PAGES_W = 7;
	localparam int PT_ENT_W      = FRAME_W + 2;

	localparam logic [TABLE_PAGES_W-1:0] TABLE_PAGES_RST = 7'd64;

	// register map, selected by paddr[2]
	localparam logic REG_USE_TLB     = 1'b0;
	localparam logic REG_TABLE_PAGES = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_XLATE  = 3'd0,
		OP_WR_PT  = 3'd1,
		OP_WR_TLB = 3'd2,
		OP_RD_PT  = 3'd3,
		OP_RD_TLB = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_BOUND   = 3'd1,
		ST_INVALID = 3'd2,
		ST_MISS    = 3'd3,
		ST_FRAME   = 3'd4
	} status_t;

	typedef struct packed {
		logic               valid;
		logic               use_bit;
		logic [FRAME_W-1:0] frame;
	} pt_ent_t;

	typedef struct packed {
		logic               valid;
		logic               use_bit;
		logic [VPAGE_W-1:0] vpage;
		logic [FRAME_W-1:0] frame;
	} tlb_ent_t;

	typedef struct packed {
		logic              wr_en;
		logic              set_use;
		logic [TLB_IW-1:0] idx;
		tlb_ent_t          wdata;
	} tlb_cmd_t;

	typedef struct packed {
		logic              hit;
		tlb_ent_t          hit_ent;
		tlb_ent_t          rd_ent;
	} tlb_rsp_t;

endpackage
`default_nettype wire

[src/vpt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[src/vpt_tlb.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpt_tlb
// Fully associative TLB in flops: parallel search, indexed read and write,
// use-bit update of the matching slot.
// ----------------------------------------------------------------------------
module vpt_tlb
	import vpt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tlb_cmd_t    cmd,
	input  wire logic [31:0] lookup_vpn,
	output tlb_rsp_t         rsp
);
	tlb_ent_t          slot_q [TLB_SLOTS];
	logic              hit;
	logic [TLB_IW-1:0] hit_slot;

	// lowest matching slot wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
			if (slot_q[i].valid && (32'(slot_q[i].vpage) == lookup_vpn)) begin
				hit      = 1'b1;
				hit_slot = TLB_IW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (cmd.wr_en) begin
			slot_q[cmd.idx] <= cmd.wdata;
		end else if (cmd.set_use && hit) begin
			slot_q[hit_slot].use_bit <= 1'b1;
		end
	end

	assign rsp.hit     = hit;
	assign rsp.hit_ent = slot_q[hit_slot];
	assign rsp.rd_ent  = slot_q[cmd.idx];

endmodule
`default_nettype wire

[src/virtual_to_physical_translator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// virtual_to_physical_translator_unit
// Address translator with a linear page table in RAM and a small TLB.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (op, vaddr, entry_*) is taken at a clock edge
//   with start high and busy low. Ops translate, write or read entries.
//   Result channel: done is high for one cycle with status, phys_addr and
//   rd_* valid; the receiver cannot stall, so it must take the item then.
//   Config: APB port, use_tlb at 0x0, table_pages at 0x4; write only while
//   no item is in flight.
// Flow:
//   An accepted item is held in the stage 1 registers and its result is
//   registered in the output registers. busy is high for the cycle after
//   accept, so no new item is taken while one is in stage 1. This is set by
//   the page-table RAM: read at accept, modify and write back (use bit,
//   entry write) from stage 1, before the next read is issued.
// Reset:
//   arst_n clears both tables (page table by per-entry written flags, TLB
//   directly), sets use_tlb to 0 and table_pages to 64. No clearing pass;
//   items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module virtual_to_physical_translator_unit
	import vpt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	// command
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [OP_W-1:0]     op,
	input  wire logic [31:0]         vaddr,
	input  wire logic [INDEX_W-1:0]  entry_index,
	input  wire logic                entry_valid,
	input  wire logic [VPAGE_W-1:0]  entry_vpage,
	input  wire logic [FRAME_W-1:0]  entry_frame,
	input  wire logic                entry_use,
	// result
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [PHYS_W-1:0]        phys_addr,
	output logic                     rd_valid,
	output logic [VPAGE_W-1:0]       rd_vpage,
	output logic [FRAME_W-1:0]       rd_frame,
	output logic                     rd_use
);
	// config registers
	logic                     use_tlb_q;
	logic [TABLE_PAGES_W-1:0] table_pages_q;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_tlb_q     <= 1'b0;
			table_pages_q <= TABLE_PAGES_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_USE_TLB:     use_tlb_q     <= pwdata[0];
				REG_TABLE_PAGES: table_pages_q <= pwdata[TABLE_PAGES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_USE_TLB:     prdata = {31'b0, use_tlb_q};
			REG_TABLE_PAGES: prdata = 32'(table_pages_q);
			default:         prdata = '0;
		endcase
	end

	// accept and stage 1
	logic                    accept;
	logic                    v_s1;
	op_t                     op_s1;
	logic [31:0]             vaddr_s1;
	logic [INDEX_W-1:0]      idx_s1;
	logic                    valid_s1;
	logic [VPAGE_W-1:0]      vpage_s1;
	logic [FRAME_W-1:0]      frame_s1;
	logic                    use_s1;
	logic                    pt_init_s1;
	logic [PT_AW-1:0]        pt_addr_s1;
	logic [PT_AW-1:0]        pt_raddr;
	logic [31:0]             in_vpn;
	logic [TABLE_DEPTH-1:0]  pt_init_q;

	assign accept = start && !busy;
	assign busy   = v_s1;
	assign in_vpn = vaddr >> OFFSET_W;
	assign pt_raddr = (op_t'(op) == OP_XLATE) ? in_vpn[PT_AW-1:0] : PT_AW'(entry_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(op);
			vaddr_s1   <= vaddr;
			idx_s1     <= entry_index;
			valid_s1   <= entry_valid;
			vpage_s1   <= entry_vpage;
			frame_s1   <= entry_frame;
			use_s1     <= entry_use;
			pt_addr_s1 <= pt_raddr;
			pt_init_s1 <= pt_init_q[pt_raddr];
		end
	end

	// page table RAM
	logic                pt_we;
	logic [PT_AW-1:0]    pt_waddr;
	pt_ent_t             pt_wdata;
	logic [PT_ENT_W-1:0] pt_rdata;
	pt_ent_t             pt_ent;

	vpt_ram #(
		.WIDTH (PT_ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (accept),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	// never-written entries read as cleared
	assign pt_ent = pt_init_s1 ? pt_ent_t'(pt_rdata) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_init_q <= '0;
		end else if (pt_we) begin
			pt_init_q[pt_waddr] <= 1'b1;
		end
	end

	// TLB
	tlb_cmd_t    tlb_cmd;
	tlb_rsp_t    tlb_rsp;
	logic [31:0] vpn_s1;

	assign vpn_s1 = vaddr_s1 >> OFFSET_W;

	vpt_tlb u_tlb (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (tlb_cmd),
		.lookup_vpn (vpn_s1),
		.rsp        (tlb_rsp)
	);

	// result and write-back
	status_t             res_status;
	logic [PHYS_W-1:0]   res_paddr;
	logic                res_rd_valid;
	logic [VPAGE_W-1:0]  res_rd_vpage;
	logic [FRAME_W-1:0]  res_rd_frame;
	logic                res_rd_use;
	logic [31:0]         bound;
	logic [OFFSET_W-1:0] offset_s1;
	logic                pt_idx_ok;
	logic                tlb_idx_ok;

	assign offset_s1  = vaddr_s1[OFFSET_W-1:0];
	assign bound      = (32'(table_pages_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
	                                                            : 32'(table_pages_q);
	assign pt_idx_ok  = 32'(idx_s1) < 32'(TABLE_DEPTH);
	assign tlb_idx_ok = 32'(idx_s1) < 32'(TLB_SLOTS);

	always_comb begin
		res_status   = ST_OK;
		res_paddr    = '0;
		res_rd_valid = 1'b0;
		res_rd_vpage = '0;
		res_rd_frame = '0;
		res_rd_use   = 1'b0;
		pt_we        = 1'b0;
		pt_waddr     = pt_addr_s1;
		pt_wdata     = '{valid: valid_s1, use_bit: use_s1, frame: frame_s1};
		tlb_cmd      = '0;
		tlb_cmd.idx  = TLB_IW'(idx_s1);
		tlb_cmd.wdata = '{valid: valid_s1, use_bit: use_s1, vpage: vpage_s1,
		                  frame: frame_s1};
		unique case (op_s1)
			OP_XLATE: begin
				if (use_tlb_q) begin
					if (!tlb_rsp.hit) begin
						res_status = ST_MISS;
					end else if (32'(tlb_rsp.hit_ent.frame) >= 32'(FRAME_COUNT)) begin
						res_status = ST_FRAME;
					end else begin
						res_paddr       = PHYS_W'((32'(tlb_rsp.hit_ent.frame) << OFFSET_W)
						                          + 32'(offset_s1));
						tlb_cmd.set_use = v_s1;
					end
				end else begin
					if (vpn_s1 >= bound) begin
						res_status = ST_BOUND;
					end else if (!pt_ent.valid) begin
						res_status = ST_INVALID;
					end else if (32'(pt_ent.frame) >= 32'(FRAME_COUNT)) begin
						res_status = ST_FRAME;
					end else begin
						res_paddr        = PHYS_W'((32'(pt_ent.frame) << OFFSET_W)
						                           + 32'(offset_s1));
						// set use bit by read-modify-write
						pt_we            = v_s1;
						pt_wdata         = pt_ent;
						pt_wdata.use_bit = 1'b1;
					end
				end
			end
			OP_WR_PT: begin
				pt_we    = v_s1 && pt_idx_ok;
				pt_waddr = PT_AW'(idx_s1);
			end
			OP_WR_TLB: begin
				tlb_cmd.wr_en = v_s1 && tlb_idx_ok;
			end
			OP_RD_PT: begin
				if (pt_idx_ok) begin
					res_rd_valid = pt_ent.valid;
					res_rd_frame = pt_ent.frame;
					res_rd_use   = pt_ent.use_bit;
				end
			end
			OP_RD_TLB: begin
				if (tlb_idx_ok) begin
					res_rd_valid = tlb_rsp.rd_ent.valid;
					res_rd_vpage = tlb_rsp.rd_ent.vpage;
					res_rd_frame = tlb_rsp.rd_ent.frame;
					res_rd_use   = tlb_rsp.rd_ent.use_bit;
				end
			end
			default: ;
		endcase
	end

	// output registers
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [PHYS_W-1:0]   paddr_q;
	logic                rd_valid_q;
	logic [VPAGE_W-1:0]  rd_vpage_q;
	logic [FRAME_W-1:0]  rd_frame_q;
	logic                rd_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			status_q   <= res_status;
			paddr_q    <= res_paddr;
			rd_valid_q <= res_rd_valid;
			rd_vpage_q <= res_rd_vpage;
			rd_frame_q <= res_rd_frame;
			rd_use_q   <= res_rd_use;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign phys_addr = paddr_q;
	assign rd_valid  = rd_valid_q;
	assign rd_vpage  = rd_vpage_q;
	assign rd_frame  = rd_frame_q;
	assign rd_use    = rd_use_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the virtual to physical translator: directed page
// table, bound and TLB cases, then bursty random traffic across several
// register settings, each response compared field by field against a
// bench-side model of both tables.
// ----------------------------------------------------------------------------
module tb_top;
	import vpt_pkg::*;

	localparam int          CLK_HALF_NS = 4;
	localparam int          RESET_CYCLES = 7;
	localparam int          SETTLE_CYCLES = 8;
	localparam longint      RUN_LIMIT_NS = 64'd3_200_000;
	localparam logic [2:0]  ADDR_USE_TLB = {REG_USE_TLB, 2'b00};
	localparam logic [2:0]  ADDR_TABLE_PAGES = {REG_TABLE_PAGES, 2'b00};
	// op codes the block must treat as no-ops
	localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    op_code;
		logic [31:0]        vaddr;
		logic [INDEX_W-1:0] idx;
		logic               valid;
		logic [VPAGE_W-1:0] vpage;
		logic [FRAME_W-1:0] frame;
		logic               use_bit;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [PHYS_W-1:0]  phys;
		logic               rd_valid;
		logic [VPAGE_W-1:0] rd_vpage;
		logic [FRAME_W-1:0] rd_frame;
		logic               rd_use;
	} rsp_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [OP_W-1:0] op = '0;
	logic [31:0] vaddr = '0;
	logic [INDEX_W-1:0] entry_index = '0;
	logic entry_valid = 1'b0;
	logic [VPAGE_W-1:0] entry_vpage = '0;
	logic [FRAME_W-1:0] entry_frame = '0;
	logic entry_use = 1'b0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [PHYS_W-1:0] phys_addr;
	logic rd_valid;
	logic [VPAGE_W-1:0] rd_vpage;
	logic [FRAME_W-1:0] rd_frame;
	logic rd_use;

	// bench copy of the translator state
	logic cfg_use_tlb = 1'b0;
	logic [TABLE_PAGES_W-1:0] cfg_table_pages = TABLE_PAGES_RST;
	pt_ent_t model_pt [TABLE_DEPTH];
	tlb_ent_t model_tlb [TLB_SLOTS];

	rsp_t owed_rsp [$];
	rsp_t got_exp;
	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int xlate_by_status [5];

	virtual_to_physical_translator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.op(op),
		.vaddr(vaddr),
		.entry_index(entry_index),
		.entry_valid(entry_valid),
		.entry_vpage(entry_vpage),
		.entry_frame(entry_frame),
		.entry_use(entry_use),
		.done(done),
		.status(status),
		.phys_addr(phys_addr),
		.rd_valid(rd_valid),
		.rd_vpage(rd_vpage),
		.rd_frame(rd_frame),
		.rd_use(rd_use)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF_NS clk = ~clk;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("CHECK FAILED");
		$finish;
	end

	// Expected response for one accepted item; updates the table copies.
	function automatic rsp_t translate_or_access(cmd_t c);
		rsp_t r;
		logic [VPAGE_W-1:0] vpn;
		logic [OFFSET_W-1:0] offset;
		int bound;
		int slot;
		int s;
		int pa;
		logic [FRAME_W-1:0] fr;
		r = '0;
		r.status = ST_OK;
		vpn = c.vaddr[31:OFFSET_W];
		offset = c.vaddr[OFFSET_W-1:0];
		case (c.op_code)
			OP_XLATE: begin
				slot = -1;
				if (!cfg_use_tlb) begin
					bound = (cfg_table_pages > TABLE_DEPTH) ? TABLE_DEPTH : cfg_table_pages;
					if (vpn >= bound) begin
						r.status = ST_BOUND;
					end else if (!model_pt[vpn].valid) begin
						r.status = ST_INVALID;
					end else if (model_pt[vpn].frame >= FRAME_COUNT) begin
						r.status = ST_FRAME;
					end else begin
						model_pt[vpn].use_bit = 1'b1;
						fr = model_pt[vpn].frame;
						slot = 0;
					end
				end else begin
					// lowest matching slot wins
					for (s = TLB_SLOTS - 1; s >= 0; s--)
						if (model_tlb[s].valid && model_tlb[s].vpage == vpn)
							slot = s;
					if (slot < 0) begin
						r.status = ST_MISS;
					end else if (model_tlb[slot].frame >= FRAME_COUNT) begin
						r.status = ST_FRAME;
						slot = -1;
					end else begin
						model_tlb[slot].use_bit = 1'b1;
						fr = model_tlb[slot].frame;
					end
				end
				if (slot >= 0) begin
					pa = int'(fr) * PAGE_BYTES + int'(offset);
					r.phys = pa[PHYS_W-1:0];
				end
			end
			OP_WR_PT: begin
				if (c.idx < TABLE_DEPTH)
					model_pt[c.idx] = '{valid: c.valid, use_bit: c.use_bit, frame: c.frame};
			end
			OP_WR_TLB: begin
				if (c.idx < TLB_SLOTS)
					model_tlb[c.idx] = '{valid: c.valid, use_bit: c.use_bit,
						vpage: c.vpage, frame: c.frame};
			end
			OP_RD_PT: begin
				if (c.idx < TABLE_DEPTH) begin
					r.rd_valid = model_pt[c.idx].valid;
					r.rd_frame = model_pt[c.idx].frame;
					r.rd_use = model_pt[c.idx].use_bit;
				end
			end
			OP_RD_TLB: begin
				if (c.idx < TLB_SLOTS) begin
					r.rd_valid = model_tlb[c.idx].valid;
					r.rd_vpage = model_tlb[c.idx].vpage;
					r.rd_frame = model_tlb[c.idx].frame;
					r.rd_use = model_tlb[c.idx].use_bit;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t mk_cmd(logic [OP_W-1:0] o, logic [31:0] va,
		logic [INDEX_W-1:0] ix, logic v, logic [VPAGE_W-1:0] vp,
		logic [FRAME_W-1:0] fr, logic u);
		cmd_t c;
		c = '{op_code: o, vaddr: va, idx: ix, valid: v, vpage: vp, frame: fr, use_bit: u};
		return c;
	endfunction

	// Random item, biased toward pages and slots that are actually populated.
	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		int k;
		logic [VPAGE_W-1:0] vpn;
		c.op_code = OP_W'($urandom);
		c.vaddr = $urandom;
		c.idx = INDEX_W'($urandom);
		c.valid = 1'($urandom);
		c.vpage = VPAGE_W'($urandom);
		c.frame = FRAME_W'($urandom);
		c.use_bit = 1'($urandom);
		pick = $urandom_range(99);
		k = $urandom_range(9);
		if (pick < 45) begin
			c.op_code = OP_XLATE;
			if (k < 8) begin
				if (cfg_use_tlb && k < 5)
					vpn = model_tlb[$urandom_range(TLB_SLOTS - 1)].vpage;
				else
					vpn = VPAGE_W'($urandom_range(TABLE_DEPTH + 8));
				c.vaddr = {vpn, c.vaddr[OFFSET_W-1:0]};
			end
		end else if (pick < 72) begin
			c.op_code = (pick < 60) ? OP_WR_PT : OP_WR_TLB;
			c.valid = ($urandom_range(99) < 85);
			if (k < 8)
				c.frame = FRAME_W'($urandom_range(FRAME_COUNT - 1));
			if (c.op_code == OP_WR_TLB) begin
				if (k < 8)
					c.idx = INDEX_W'($urandom_range(TLB_SLOTS - 1));
				pick = $urandom_range(9);
				if (pick < 5)
					c.vpage = VPAGE_W'($urandom_range(TABLE_DEPTH + 8));
				else if (pick < 7)
					c.vpage = model_tlb[$urandom_range(TLB_SLOTS - 1)].vpage;
			end
		end else if (pick < 96) begin
			c.op_code = (pick < 84) ? OP_RD_PT : OP_RD_TLB;
			if (c.op_code == OP_RD_TLB && k < 8)
				c.idx = INDEX_W'($urandom_range(TLB_SLOTS - 1));
		end else begin
			c.op_code = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
		end
		return c;
	endfunction

	// Leaves start high; caller lowers it through pause_sender or wait_idle.
	task automatic send_item(cmd_t c);
		rsp_t r;
		op <= c.op_code;
		vaddr <= c.vaddr;
		entry_index <= c.idx;
		entry_valid <= c.valid;
		entry_vpage <= c.vpage;
		entry_frame <= c.frame;
		entry_use <= c.use_bit;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		r = translate_or_access(c);
		owed_rsp.push_back(r);
		items_sent++;
		if (c.op_code == OP_XLATE)
			xlate_by_status[int'(r.status)]++;
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (owed_rsp.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write, then read back to confirm the register holds the value.
	task automatic set_register(logic [2:0] addr, logic [31:0] value);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_USE_TLB) begin
			cfg_use_tlb = value[0];
			want = {31'b0, cfg_use_tlb};
		end else begin
			cfg_table_pages = value[TABLE_PAGES_W-1:0];
			want = {{(32 - TABLE_PAGES_W){1'b0}}, cfg_table_pages};
		end
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want) begin
			$error("prdata mismatch at 0x%0h: expected 0x%0h, got 0x%0h", addr, want, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (owed_rsp.size() == 0) begin
				$error("result with nothing outstanding: status %0d", status);
				fail_count++;
			end else begin
				got_exp = owed_rsp.pop_front();
				check_field("status", got_exp.status, status);
				check_field("phys_addr", got_exp.phys, phys_addr);
				check_field("rd_valid", got_exp.rd_valid, rd_valid);
				check_field("rd_vpage", got_exp.rd_vpage, rd_vpage);
				check_field("rd_frame", got_exp.rd_frame, rd_frame);
				check_field("rd_use", got_exp.rd_use, rd_use);
			end
		end
	end

	// Runs on reset defaults: linear table mode, 64 pages in use.
	task automatic test_page_table_directed();
		send_item(mk_cmd(OP_XLATE, 32'd0, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_PT, 32'd0, 6'd0, 1'b1, '0, 8'd31, 1'b0));
		send_item(mk_cmd(OP_XLATE, 32'd127, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_RD_PT, 32'd0, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_PT, 32'd0, 6'd63, 1'b1, '0, 8'd32, 1'b0));
		send_item(mk_cmd(OP_XLATE, 32'd63 * PAGE_BYTES + 5, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		pause_sender(3);
		send_item(mk_cmd(OP_WR_PT, 32'd0, 6'd5, 1'b0, '0, 8'd3, 1'b1));
		send_item(mk_cmd(OP_XLATE, 32'd5 * PAGE_BYTES, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_PT, '1, 6'd1, 1'b1, '1, 8'd255, 1'b1));
		send_item(mk_cmd(OP_RD_PT, 32'd0, 6'd1, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_XLATE, 32'hFFFF_FFFF, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_RSVD_LO, '1, '1, 1'b1, '1, '1, 1'b1));
		send_item(mk_cmd(OP_RSVD_HI, '1, '1, 1'b1, '1, '1, 1'b1));
		wait_idle();
	endtask

	task automatic test_table_bound_directed();
		set_register(ADDR_TABLE_PAGES, 32'd0);
		send_item(mk_cmd(OP_XLATE, 32'd0, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		wait_idle();
		// above the table depth the bound clamps to the depth
		set_register(ADDR_TABLE_PAGES, 32'd127);
		send_item(mk_cmd(OP_XLATE, 32'd63 * PAGE_BYTES, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_XLATE, 32'd64 * PAGE_BYTES, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		wait_idle();
		set_register(ADDR_TABLE_PAGES, 32'd1);
		send_item(mk_cmd(OP_XLATE, 32'd127, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		wait_idle();
	endtask

	task automatic test_tlb_directed();
		set_register(ADDR_USE_TLB, 32'd1);
		set_register(ADDR_TABLE_PAGES, 32'd64);
		send_item(mk_cmd(OP_WR_TLB, 32'd0, 6'd0, 1'b1, '1, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_TLB, 32'd0, 6'd3, 1'b1, '1, 8'd7, 1'b0));
		send_item(mk_cmd(OP_XLATE, 32'hFFFF_FFFF, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_TLB, 32'd0, 6'd1, 1'b1, 25'd2, 8'd32, 1'b0));
		send_item(mk_cmd(OP_XLATE, 32'd2 * PAGE_BYTES, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_TLB, 32'd0, 6'd2, 1'b0, 25'd3, 8'd1, 1'b1));
		send_item(mk_cmd(OP_XLATE, 32'd3 * PAGE_BYTES, 6'd0, 1'b0, '0, 8'd0, 1'b0));
		send_item(mk_cmd(OP_WR_TLB, 32'd0, 6'd4, 1'b1, 25'd9, 8'd1, 1'b1));
		send_item(mk_cmd(OP_RD_TLB, 32'd0, 6'd63, 1'b0, '0, 8'd0, 1'b0));
		// failed lookup leaves the use bit clear
		send_item(mk_cmd(OP_RD_TLB, 32'd0, 6'd1, 1'b0, '0, 8'd0, 1'b0));
		wait_idle();
	endtask

	task automatic test_random_traffic(logic use_tlb, int pages, int count);
		int burst;
		set_register(ADDR_USE_TLB, {31'b0, use_tlb});
		set_register(ADDR_TABLE_PAGES, pages);
		burst = $urandom_range(1, 16);
		repeat (count) begin
			send_item(random_cmd());
			burst--;
			if ($urandom_range(39) == 0) begin
				wait_idle();
			end else if (burst == 0) begin
				if ($urandom_range(5) != 0)
					pause_sender($urandom_range(1, 8));
				burst = $urandom_range(1, 16);
			end
		end
		wait_idle();
	endtask

	initial begin
		foreach (model_pt[i])
			model_pt[i] = '0;
		foreach (model_tlb[i])
			model_tlb[i] = '0;
		foreach (xlate_by_status[i])
			xlate_by_status[i] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_page_table_directed();
		test_table_bound_directed();
		test_tlb_directed();
		test_random_traffic(1'b0, 64, 200);
		test_random_traffic(1'b1, 64, 200);
		test_random_traffic(1'b0, $urandom_range(1, 63), 120);
		test_random_traffic(1'b1, 127, 120);
		test_random_traffic(1'b0, 127, 60);
		test_random_traffic(1'b0, 0, 30);

		if (owed_rsp.size() != 0) begin
			$error("%0d results never arrived", owed_rsp.size());
			fail_count++;
		end
		$display("Sent %0d items, checked %0d results, in table and TLB mode.",
			items_sent, results_seen);
		$display("Translations: %0d ok, %0d bound, %0d invalid, %0d miss, %0d bad frame.",
			xlate_by_status[ST_OK], xlate_by_status[ST_BOUND], xlate_by_status[ST_INVALID],
			xlate_by_status[ST_MISS], xlate_by_status[ST_FRAME]);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[virtual_to_physical_translator_unit.f]
src/vpt_pkg.sv
src/vpt_ram.sv
src/vpt_tlb.sv
src/virtual_to_physical_translator_unit.sv
tb/tb_top.sv
